// ===== sv/vfdfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfdfc_pkg
// Shared types, codes and helper functions of the display command formatter.
// ----------------------------------------------------------------------------
package vfdfc_pkg;

  // Frame geometry defaults and limits
  localparam int COLUMNS_DEF = 9;
  localparam int ROWS_DEF    = 1;
  localparam int ADDR_W      = 6;   // 16 columns x 4 rows at most

  // Request codes
  localparam logic [2:0] REQ_WRITE     = 3'd0;
  localparam logic [2:0] REQ_CLEAR     = 3'd1;
  localparam logic [2:0] REQ_FLUSH     = 3'd2;
  localparam logic [2:0] REQ_BACKLIGHT = 3'd3;
  localparam logic [2:0] REQ_REC_LED   = 3'd4;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 10;
  localparam logic [CFG_INDEX_W-1:0] CFG_ON_BRIGHTNESS  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFF_BRIGHTNESS = 1'd1;
  localparam logic [CFG_DATA_W-1:0]  ON_BRIGHTNESS_RST  = 10'd1000;
  localparam logic [CFG_DATA_W-1:0]  OFF_BRIGHTNESS_RST = 10'd0;

  // Command bytes
  localparam logic [7:0] BYTE_LEAD      = 8'ha0;
  localparam logic [7:0] BYTE_ZERO      = 8'h00;
  localparam logic [7:0] BYTE_FRAME     = 8'h80;
  localparam logic [7:0] BYTE_FRAME_ARG = 8'h8a;
  localparam logic [7:0] BYTE_BACKLIGHT = 8'h50;
  localparam logic [7:0] BYTE_REC_LED   = 8'h32;
  localparam logic [7:0] BYTE_ONE_ARG   = 8'h81;
  localparam logic [7:0] SPACE_CHAR     = 8'h20;

  // Header byte positions
  localparam logic [2:0] HDR_POS_LEAD = 3'd0;
  localparam logic [2:0] HDR_POS_ZERO = 3'd1;
  localparam logic [2:0] HDR_POS_B2   = 3'd2;
  localparam logic [2:0] HDR_POS_B3   = 3'd3;
  localparam logic [2:0] HDR_POS_LAST = 3'd4;

  typedef struct packed {
    logic [2:0] req_type;
    logic [3:0] column;
    logic [1:0] row;
    logic [7:0] char_code;
    logic       switch_on;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_CLEAR,
    CMD_FLUSH,
    CMD_EMIT
  } cmd_kind_t;

  // Classified command passed from front to back
  typedef struct packed {
    cmd_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        char_code;
    logic [7:0]        b2;
    logic [7:0]        b3;
    logic [7:0]        b4;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HDR,
    BK_CELL
  } back_state_t;

  function automatic logic [7:0] level_code(input logic [CFG_DATA_W-1:0] level);
    logic [7:0] code;
    if (level < 10'd300) begin
      code = 8'd0;
    end else if (level >= 10'd700) begin
      code = 8'd1;
    end else begin
      code = 8'd2;
    end
    return code;
  endfunction

  // Fold case, strip accents, blank anything the display cannot show
  function automatic logic [7:0] sanitize(input logic [7:0] c_in);
    logic [7:0] c;
    logic [7:0] res;
    c = c_in;
    if ((c >= 8'd224 && c <= 8'd253) || (c >= 8'd97 && c <= 8'd122)) begin
      c = c - 8'd32;
    end
    if (c >= 8'd48 && c <= 8'd57) begin
      res = c;
    end else if (c >= 8'd65 && c <= 8'd90) begin
      res = c;
    end else if (c == 8'd42 || c == 8'd43 || c == 8'd45 || c == 8'd47) begin
      res = c;
    end else if (c == 8'd223) begin
      res = 8'd83;
    end else if (c >= 8'd192 && c <= 8'd197) begin
      res = 8'd65;
    end else if (c >= 8'd200 && c <= 8'd203) begin
      res = 8'd69;
    end else if (c >= 8'd204 && c <= 8'd207) begin
      res = 8'd73;
    end else if (c >= 8'd210 && c <= 8'd214) begin
      res = 8'd79;
    end else if (c >= 8'd217 && c <= 8'd220) begin
      res = 8'd85;
    end else begin
      res = SPACE_CHAR;
    end
    return res;
  endfunction

endpackage

// ===== sv/vfdfc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfdfc_front
// Accepts request items, holds the brightness registers and turns each kept
// request into a command for the back end (out-of-frame writes and unused codes are dropped).
// ----------------------------------------------------------------------------
module vfdfc_front #(
  parameter int COLUMNS = vfdfc_pkg::COLUMNS_DEF,
  parameter int ROWS    = vfdfc_pkg::ROWS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  vfdfc_pkg::in_item_t                  in_item,
  input  logic                                 cfg_we,
  input  logic [vfdfc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [vfdfc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                 push,
  output vfdfc_pkg::cmd_t                      push_cmd,
  input  logic                                 q_full
);

  logic [vfdfc_pkg::CFG_DATA_W-1:0] on_bright_r, on_bright_nxt;
  logic [vfdfc_pkg::CFG_DATA_W-1:0] off_bright_r, off_bright_nxt;
  logic                             keep;
  logic                             in_frame;

  always_comb begin
    on_bright_nxt  = on_bright_r;
    off_bright_nxt = off_bright_r;
    if (cfg_we) begin
      if (cfg_index == vfdfc_pkg::CFG_ON_BRIGHTNESS) begin
        on_bright_nxt = cfg_wdata;
      end
      if (cfg_index == vfdfc_pkg::CFG_OFF_BRIGHTNESS) begin
        off_bright_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_bright_r  <= vfdfc_pkg::ON_BRIGHTNESS_RST;
      off_bright_r <= vfdfc_pkg::OFF_BRIGHTNESS_RST;
    end else begin
      on_bright_r  <= on_bright_nxt;
      off_bright_r <= off_bright_nxt;
    end
  end

  assign in_stall = q_full;
  assign in_frame = ({1'b0, in_item.column} < 5'(COLUMNS)) &&
                    ({1'b0, in_item.row} < 3'(ROWS));

  always_comb begin
    keep               = 1'b0;
    push_cmd.kind      = vfdfc_pkg::CMD_WRITE;
    push_cmd.addr      = vfdfc_pkg::ADDR_W'(in_item.row) *
                         vfdfc_pkg::ADDR_W'(COLUMNS) +
                         vfdfc_pkg::ADDR_W'(in_item.column);
    push_cmd.char_code = in_item.char_code;
    push_cmd.b2        = vfdfc_pkg::BYTE_FRAME;
    push_cmd.b3        = vfdfc_pkg::BYTE_FRAME_ARG;
    push_cmd.b4        = vfdfc_pkg::BYTE_FRAME_ARG;
    unique case (in_item.req_type)
      vfdfc_pkg::REQ_WRITE: begin
        keep          = in_frame;
        push_cmd.kind = vfdfc_pkg::CMD_WRITE;
      end
      vfdfc_pkg::REQ_CLEAR: begin
        keep          = 1'b1;
        push_cmd.kind = vfdfc_pkg::CMD_CLEAR;
      end
      vfdfc_pkg::REQ_FLUSH: begin
        keep          = 1'b1;
        push_cmd.kind = vfdfc_pkg::CMD_FLUSH;
      end
      vfdfc_pkg::REQ_BACKLIGHT: begin
        keep          = 1'b1;
        push_cmd.kind = vfdfc_pkg::CMD_EMIT;
        push_cmd.b2   = vfdfc_pkg::BYTE_BACKLIGHT;
        push_cmd.b3   = vfdfc_pkg::BYTE_ONE_ARG;
        push_cmd.b4   = vfdfc_pkg::level_code(in_item.switch_on ? on_bright_r
                                                                : off_bright_r);
      end
      vfdfc_pkg::REQ_REC_LED: begin
        keep          = 1'b1;
        push_cmd.kind = vfdfc_pkg::CMD_EMIT;
        push_cmd.b2   = vfdfc_pkg::BYTE_REC_LED;
        push_cmd.b3   = vfdfc_pkg::BYTE_ONE_ARG;
        push_cmd.b4   = {7'd0, in_item.switch_on};
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = in_valid && !q_full && keep;

endmodule

// ===== sv/vfdfc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfdfc_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module vfdfc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  vfdfc_pkg::cmd_t push_cmd,
  output logic            q_full,
  input  logic            pop,
  output vfdfc_pkg::cmd_t pop_cmd,
  output logic            q_avail
);

  vfdfc_pkg::cmd_t ent_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;

  assign q_full  = (count_r == 2'd2);
  assign q_avail = (count_r != 2'd0);
  assign pop_cmd = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/vfdfc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfdfc_back
// Executes commands: keeps the frame memory, emits header and cell bytes
// through a registered output stage.
// ----------------------------------------------------------------------------
module vfdfc_back #(
  parameter int COLUMNS = vfdfc_pkg::COLUMNS_DEF,
  parameter int ROWS    = vfdfc_pkg::ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_avail,
  input  vfdfc_pkg::cmd_t      pop_cmd,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output vfdfc_pkg::out_item_t out_item
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  vfdfc_pkg::back_state_t state_r, state_nxt;
  vfdfc_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [2:0]             hdr_pos_r, hdr_pos_nxt;
  logic [AW-1:0]          cell_idx_r, cell_idx_nxt;
  logic [CELLS-1:0]       vld_r, vld_nxt;
  logic                   out_valid_r, out_valid_nxt;
  vfdfc_pkg::out_item_t   out_item_r, out_item_nxt;

  logic [7:0]             mem [CELLS];
  logic [7:0]             rd_data_r;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [7:0]             mem_wdata;
  logic                   can_load;
  logic [7:0]             cell_clean;
  logic [7:0]             hdr_byte;

  assign can_load   = !out_valid_r || !out_stall;
  assign cell_clean = vfdfc_pkg::sanitize(vld_r[cell_idx_r] ? rd_data_r
                                                            : vfdfc_pkg::SPACE_CHAR);

  always_comb begin
    unique case (hdr_pos_r)
      vfdfc_pkg::HDR_POS_LEAD: hdr_byte = vfdfc_pkg::BYTE_LEAD;
      vfdfc_pkg::HDR_POS_ZERO: hdr_byte = vfdfc_pkg::BYTE_ZERO;
      vfdfc_pkg::HDR_POS_B2:   hdr_byte = cmd_r.b2;
      vfdfc_pkg::HDR_POS_B3:   hdr_byte = cmd_r.b3;
      default:                 hdr_byte = cmd_r.b4;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    hdr_pos_nxt   = hdr_pos_r;
    cell_idx_nxt  = cell_idx_r;
    vld_nxt       = vld_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    pop           = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = cell_idx_r;
    mem_wdata     = cell_clean;
    unique case (state_r)
      vfdfc_pkg::BK_IDLE: begin
        if (q_avail) begin
          pop = 1'b1;
          unique case (pop_cmd.kind)
            vfdfc_pkg::CMD_WRITE: begin
              mem_we             = 1'b1;
              mem_waddr          = pop_cmd.addr[AW-1:0];
              mem_wdata          = pop_cmd.char_code;
              vld_nxt[mem_waddr] = 1'b1;
            end
            vfdfc_pkg::CMD_CLEAR: begin
              vld_nxt = '0;
            end
            default: begin
              cmd_nxt      = pop_cmd;
              hdr_pos_nxt  = vfdfc_pkg::HDR_POS_LEAD;
              cell_idx_nxt = '0;
              state_nxt    = vfdfc_pkg::BK_HDR;
            end
          endcase
        end
      end
      vfdfc_pkg::BK_HDR: begin
        if (can_load) begin
          out_valid_nxt         = 1'b1;
          out_item_nxt.out_byte = hdr_byte;
          out_item_nxt.last     = (hdr_pos_r == vfdfc_pkg::HDR_POS_LAST) &&
                                  (cmd_r.kind == vfdfc_pkg::CMD_EMIT);
          hdr_pos_nxt           = hdr_pos_r + 3'd1;
          if (hdr_pos_r == vfdfc_pkg::HDR_POS_LAST) begin
            state_nxt = (cmd_r.kind == vfdfc_pkg::CMD_FLUSH) ? vfdfc_pkg::BK_CELL
                                                             : vfdfc_pkg::BK_IDLE;
          end
        end
      end
      vfdfc_pkg::BK_CELL: begin
        if (can_load) begin
          // Emit the cleaned cell and store it back
          out_valid_nxt         = 1'b1;
          out_item_nxt.out_byte = cell_clean;
          out_item_nxt.last     = (cell_idx_r == AW'(CELLS - 1));
          mem_we                = 1'b1;
          vld_nxt[cell_idx_r]   = 1'b1;
          if (cell_idx_r == AW'(CELLS - 1)) begin
            state_nxt = vfdfc_pkg::BK_IDLE;
          end else begin
            cell_idx_nxt = cell_idx_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = vfdfc_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vfdfc_pkg::BK_IDLE;
      hdr_pos_r   <= vfdfc_pkg::HDR_POS_LEAD;
      cell_idx_r  <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hdr_pos_r   <= hdr_pos_nxt;
      cell_idx_r  <= cell_idx_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_item_r <= out_item_nxt;
  end

  // Frame memory: one write port, one registered read at the next cell
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[cell_idx_nxt];
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== sv/vfd_frame_command_formatter_core.sv =====
`timescale 1ns / 1ps
// An accepted request item reaches the output through the queue entry, the back-end command
// register and the output register. Throughput: one byte per cycle while out_stall is low;
// a flush sends the header then one byte per cell, a backlight or record-LED command the header.
// Reset (synchronous, rst_n low): queue and output empty, frame reads as spaces,
// on_brightness 1000, off_brightness 0.
// ----------------------------------------------------------------------------
// vfd_frame_command_formatter_core
// Character frame keeper and command byte formatter for a display of one line by default.
// ----------------------------------------------------------------------------
module vfd_frame_command_formatter_core #(
  parameter int COLUMNS = vfdfc_pkg::COLUMNS_DEF,
  parameter int ROWS    = vfdfc_pkg::ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  vfdfc_pkg::in_item_t               in_item,
  // Byte channel to the display link
  output logic                              out_valid,
  input  logic                              out_stall,
  output vfdfc_pkg::out_item_t              out_item,
  // Configuration writes
  input  logic                              cfg_we,
  input  logic [vfdfc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vfdfc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic            push;
  vfdfc_pkg::cmd_t push_cmd;
  logic            q_full;
  logic            pop;
  vfdfc_pkg::cmd_t pop_cmd;
  logic            q_avail;

  // Front: classify requests, drop out-of-frame writes and unused codes,
  // resolve the backlight code from the brightness registers
  vfdfc_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  // Hold commands while the back end works through a run
  vfdfc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_avail  (q_avail)
  );

  // Back: update the frame, emit header and cell bytes in order
  vfdfc_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_avail   (q_avail),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
